>>> rtl/core/d2f_pkg.sv
// Package: constants for the directed double-to-single narrowing block.
`timescale 1ns / 1ps
`default_nettype none
package d2f_pkg;
   localparam logic [31:0] FLT_MAX_BITS = 32'h7F7F_FFFF;
   localparam logic [31:0] QNAN_BITS    = 32'h7FC0_0000;
   localparam logic [10:0] EXP_ALL_ONES = 11'h7FF;
   localparam logic [10:0] EXP_MAX_NORM = 11'd1150;   // 1023 + 127
   localparam logic [10:0] EXP_MIN_NORM = 11'd897;    // 1023 - 126
   localparam logic [10:0] SUB_SHIFT_BASE = 11'd926;
endpackage
`default_nettype wire

>>> rtl/core/double_to_float_directed_round.sv
// Top level: directed rounding of a binary64 pattern to a saturated binary32 pattern.
// Path: the accepting edge loads the input register, then the result register drives the strobed result.
// Throughput: one request per cycle; busy is held low, there is no internal stall.
// The whole conversion sits between the input register and the result register.
// Reset: synchronous, active high; clears the valid pipeline only, payloads are not reset.
// The receiver cannot stall: each result is shown for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none
module double_to_float_directed_round (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [63:0] req_value_bits,
   input  wire logic        req_action,
   output logic             rsp_valid,
   output logic [31:0]      rsp_result_bits
);
   logic        vld_ff;
   logic [63:0] bits_ff;
   logic        up_ff;
   logic        out_vld_ff;
   logic [31:0] res_ff, res_in;

   logic        sign;
   logic [10:0] expo;
   logic [51:0] frac;
   logic [52:0] sig;
   logic [10:0] sh;
   logic [52:0] shifted;
   logic [52:0] lost_mask;
   logic [31:0] mag;
   logic        inexact;
   logic [31:0] mag_r;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         vld_ff     <= start;
         out_vld_ff <= vld_ff;
      end
      if (start) begin
         bits_ff <= req_value_bits;
         up_ff   <= req_action;
      end
      res_ff <= res_in;
   end

   always_comb begin
      sign = bits_ff[63];
      expo = bits_ff[62:52];
      frac = bits_ff[51:0];
      sig  = (expo == 11'd0) ? {1'b0, frac} : {1'b1, frac};
      sh   = d2f_pkg::SUB_SHIFT_BASE - ((expo == 11'd0) ? 11'd1 : expo);
      shifted   = '0;
      lost_mask = '1;
      if (sh < 11'd53) begin
         shifted   = sig >> sh[5:0];
         lost_mask = ~({53{1'b1}} << sh[5:0]);
      end
      mag = '0;
      inexact = 1'b0;
      if (expo >= d2f_pkg::EXP_MIN_NORM) begin
         mag = {1'b0, 8'(expo - d2f_pkg::EXP_MIN_NORM + 11'd1), frac[51:29]};
         inexact = frac[28:0] != '0;
      end else begin
         // shift is at least 30, so the subnormal magnitude fits in 23 bits
         mag = {9'd0, shifted[22:0]};
         inexact = (sig & lost_mask) != '0;
      end
      // away from zero when direction and sign agree
      mag_r = mag + {31'd0, inexact && (up_ff != sign)};
      if (mag_r > d2f_pkg::FLT_MAX_BITS) mag_r = d2f_pkg::FLT_MAX_BITS;
      res_in = {sign, mag_r[30:0]};
      if (expo == d2f_pkg::EXP_ALL_ONES) begin
         if (frac != '0)
            res_in = {sign, 31'd0} | d2f_pkg::QNAN_BITS | {10'd0, frac[50:29]};
         else
            res_in = {sign, d2f_pkg::FLT_MAX_BITS[30:0]};
      end else if (expo > d2f_pkg::EXP_MAX_NORM) begin
         res_in = {sign, d2f_pkg::FLT_MAX_BITS[30:0]};
      end
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_result_bits = res_ff;

   a_lat: assert property (@(posedge clock) disable iff (reset) start |=> ##1 rsp_valid)
      else $error("result strobe missing two cycles after request");
   a_no_inf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_result_bits[30:23] != 8'hFF || rsp_result_bits[22:0] != 23'd0))
      else $error("infinite result produced");
   a_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_bits[30:23] == 8'hFF |-> rsp_result_bits[22])
      else $error("NaN result not quiet");
endmodule
`default_nettype wire
